// ----- rtl/ps2mc_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2mc_pkg
// Shared widths, codes and reset values for the PS/2 mouse cursor block.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned ColW    = 7;
    localparam int unsigned RowW    = 5;
    localparam int unsigned BtnW    = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 7;
    localparam int unsigned PosW    = 2;

    localparam int unsigned StReadyBit = 0;
    localparam int unsigned StAuxBit   = 5;
    localparam int unsigned SyncBit    = 3;

    localparam logic [ByteW-1:0] AckByte = 8'hFA;

    localparam logic [CfgIdxW-1:0] RegScreenColumns = 2'd0;
    localparam logic [CfgIdxW-1:0] RegScreenRows    = 2'd1;

    localparam logic [ColW-1:0] ResetColumns = 7'd80;
    localparam logic [RowW-1:0] ResetRows    = 5'd25;
    localparam logic [ColW-1:0] ResetCol     = 7'd40;
    localparam logic [RowW-1:0] ResetRow     = 5'd12;

endpackage

// ----- rtl/ps2mc_if.sv -----
// ----------------------------------------------------------------------------
// ps2mc_if
// Valid/ready channels of the PS/2 mouse cursor block.
// ----------------------------------------------------------------------------
interface ps2mc_req_if;
    logic                         valid;
    logic                         ready;
    logic [ps2mc_pkg::ByteW-1:0]  ctrl_status;
    logic [ps2mc_pkg::ByteW-1:0]  rx_byte;

    modport source (output valid, output ctrl_status, output rx_byte, input ready);
    modport sink   (input valid, input ctrl_status, input rx_byte, output ready);
endinterface

interface ps2mc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ps2mc_pkg::BtnW-1:0]   button_bits;
    logic [ps2mc_pkg::ColW-1:0]   cursor_col;
    logic [ps2mc_pkg::RowW-1:0]   cursor_row;
    logic                         packet_applied;

    modport source (output valid, output button_bits, output cursor_col,
                    output cursor_row, output packet_applied, input ready);
    modport sink   (input valid, input button_bits, input cursor_col,
                    input cursor_row, input packet_applied, output ready);
endinterface

interface ps2mc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ps2mc_pkg::CfgIdxW-1:0]  index;
    logic [ps2mc_pkg::CfgDatW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ps2_mouse_packet_cursor.sv -----
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// Collects three-byte PS/2 mouse packets from controller reads and keeps a
// clamped text-screen cursor and button state.
//
//   channel  dir  payload                                       
//   req      in   ctrl_status, rx_byte                          
//   rsp      out  button_bits, cursor_col, cursor_row, packet_applied
//   cfg      in   index, data (0 screen_columns, 1 screen_rows) 
//
// One transaction per cycle sustained while rsp is ready; the result passes
// through the input register, then the result register.
// A stalled rsp holds the result; req keeps accepting while the input
// register can drain into the result register.
// Reset: cursor 40/12, buttons 0, screen 80x25, packet position 0.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor (
    input  logic               clk,
    input  logic               rst_n,
    ps2mc_req_if.sink          req,
    ps2mc_rsp_if.source        rsp,
    ps2mc_cfg_if.sink          cfg
);

    localparam int unsigned SumW = ps2mc_pkg::ByteW + 1;

    logic                            in_valid_reg;
    logic [ps2mc_pkg::ByteW-1:0]     in_status_reg;
    logic [ps2mc_pkg::ByteW-1:0]     in_byte_reg;

    logic [ps2mc_pkg::ColW-1:0]      cols_reg;
    logic [ps2mc_pkg::RowW-1:0]      rows_reg;

    logic [ps2mc_pkg::PosW-1:0]      pos_reg, pos_next;
    logic [ps2mc_pkg::ByteW-1:0]     pkt0_reg, pkt1_reg;
    logic [ps2mc_pkg::ColW-1:0]      col_reg, col_next;
    logic [ps2mc_pkg::RowW-1:0]      row_reg, row_next;
    logic [ps2mc_pkg::BtnW-1:0]      btn_reg, btn_next;
    logic                            applied_next;

    logic                            out_valid_reg;
    logic [ps2mc_pkg::BtnW-1:0]      out_btn_reg;
    logic [ps2mc_pkg::ColW-1:0]      out_col_reg;
    logic [ps2mc_pkg::RowW-1:0]      out_row_reg;
    logic                            out_applied_reg;

    logic                            advance;
    logic                            take;
    logic signed [SumW-1:0]          col_sum, row_sum;
    logic [ps2mc_pkg::ColW-1:0]      col_top;
    logic [ps2mc_pkg::RowW-1:0]      row_top;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign take = in_status_reg[ps2mc_pkg::StReadyBit]
               && in_status_reg[ps2mc_pkg::StAuxBit]
               && (in_byte_reg != ps2mc_pkg::AckByte);

    assign col_top = (cols_reg == '0) ? '0 : cols_reg - 1'b1;
    assign row_top = (rows_reg == '0) ? '0 : rows_reg - 1'b1;

    assign col_sum = $signed({2'b00, col_reg}) + $signed({pkt1_reg[7], pkt1_reg});
    assign row_sum = $signed({4'b0000, row_reg}) - $signed({in_byte_reg[7], in_byte_reg});

    always_comb
    begin
        pos_next     = pos_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        btn_next     = btn_reg;
        applied_next = 1'b0;
        if (take)
        begin
            if (pos_reg < 2'd2)
            begin
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                pos_next = '0;
                if (pkt0_reg[ps2mc_pkg::SyncBit])
                begin
                    applied_next = 1'b1;
                    btn_next     = pkt0_reg[ps2mc_pkg::BtnW-1:0];
                    if (col_sum[SumW-1])
                        col_next = '0;
                    else if (col_sum > $signed({2'b00, col_top}))
                        col_next = col_top;
                    else
                        col_next = col_sum[ps2mc_pkg::ColW-1:0];
                    if (row_sum[SumW-1])
                        row_next = '0;
                    else if (row_sum > $signed({4'b0000, row_top}))
                        row_next = row_top;
                    else
                        row_next = row_sum[ps2mc_pkg::RowW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cols_reg      <= ps2mc_pkg::ResetColumns;
            rows_reg      <= ps2mc_pkg::ResetRows;
            pos_reg       <= '0;
            col_reg       <= ps2mc_pkg::ResetCol;
            row_reg       <= ps2mc_pkg::ResetRow;
            btn_reg       <= '0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                pos_reg <= pos_next;
                col_reg <= col_next;
                row_reg <= row_next;
                btn_reg <= btn_next;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    ps2mc_pkg::RegScreenColumns: cols_reg <= cfg.data;
                    ps2mc_pkg::RegScreenRows:    rows_reg <= cfg.data[ps2mc_pkg::RowW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_status_reg <= req.ctrl_status;
            in_byte_reg   <= req.rx_byte;
        end
        if (advance && take && (pos_reg == 2'd0))
            pkt0_reg <= in_byte_reg;
        if (advance && take && (pos_reg == 2'd1))
            pkt1_reg <= in_byte_reg;
        if (advance)
        begin
            out_btn_reg     <= btn_next;
            out_col_reg     <= col_next;
            out_row_reg     <= row_next;
            out_applied_reg <= applied_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.button_bits    = out_btn_reg;
    assign rsp.cursor_col     = out_col_reg;
    assign rsp.cursor_row     = out_row_reg;
    assign rsp.packet_applied = out_applied_reg;

endmodule

// ----- dv/ps2_mouse_packet_cursor_test.sv -----
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_test
// Self-checking bench for the PS/2 mouse cursor block. Controller reads are
// driven on the req channel and the cursor state returned on rsp is compared
// with a scoreboard that tracks packet position, buttons and the clamped
// cursor. A short directed sequence comes first, then mostly well-formed
// packets mixed with noise under several screen sizes, with random stalls on
// both channels and one long stall on the result side.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ps2mc_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
    localparam logic [ps2mc_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;
    localparam logic [ps2mc_pkg::ByteW-1:0] ReadyAux =
        (8'd1 << ps2mc_pkg::StReadyBit) | (8'd1 << ps2mc_pkg::StAuxBit);
    localparam logic [ps2mc_pkg::ByteW-1:0] SyncMask = 8'd1 << ps2mc_pkg::SyncBit;
    localparam int unsigned LongHold  = 200;
    localparam int unsigned DrainWait = 4;

    typedef struct packed {
        logic [ps2mc_pkg::BtnW-1:0] buttons;
        logic [ps2mc_pkg::ColW-1:0] col;
        logic [ps2mc_pkg::RowW-1:0] row;
        logic                       applied;
    } cursor_state_t;

    class cursor_scoreboard;
        cursor_state_t               expected_q[$];
        int unsigned                 errors;
        logic [ps2mc_pkg::ColW-1:0]  screen_cols;
        logic [ps2mc_pkg::RowW-1:0]  screen_rows;
        logic [ps2mc_pkg::PosW-1:0]  byte_pos;
        logic [ps2mc_pkg::ByteW-1:0] pkt[2];
        logic [ps2mc_pkg::ColW-1:0]  col;
        logic [ps2mc_pkg::RowW-1:0]  row;
        logic [ps2mc_pkg::BtnW-1:0]  buttons;

        function new();
            errors      = 0;
            screen_cols = ps2mc_pkg::ResetColumns;
            screen_rows = ps2mc_pkg::ResetRows;
            byte_pos    = '0;
            pkt[0]      = '0;
            pkt[1]      = '0;
            col         = ps2mc_pkg::ResetCol;
            row         = ps2mc_pkg::ResetRow;
            buttons     = '0;
        endfunction

        function void write_reg(logic [ps2mc_pkg::CfgIdxW-1:0] idx,
                                logic [ps2mc_pkg::CfgDatW-1:0] value);
            if (idx == ps2mc_pkg::RegScreenColumns)
                screen_cols = value;
            else if (idx == ps2mc_pkg::RegScreenRows)
                screen_rows = value[ps2mc_pkg::RowW-1:0];
        endfunction

        // a screen size of 0 behaves like 1
        function int clamp(int v, int limit);
            int top;
            top = (limit == 0) ? 0 : limit - 1;
            if (v < 0)
                return 0;
            if (v > top)
                return top;
            return v;
        endfunction

        function void note_input(logic [ps2mc_pkg::ByteW-1:0] st,
                                 logic [ps2mc_pkg::ByteW-1:0] db);
            cursor_state_t r;
            logic          applied;
            int            col_i;
            int            row_i;
            applied = 1'b0;
            if (st[ps2mc_pkg::StReadyBit] && st[ps2mc_pkg::StAuxBit]
                && db != ps2mc_pkg::AckByte)
            begin
                if (byte_pos < 2)
                begin
                    pkt[byte_pos[0]] = db;
                    byte_pos = byte_pos + 1'b1;
                end
                else
                begin
                    byte_pos = '0;
                    if (pkt[0][ps2mc_pkg::SyncBit])
                    begin
                        buttons = pkt[0][ps2mc_pkg::BtnW-1:0];
                        col_i = clamp(int'(col) + int'($signed(pkt[1])),
                                      int'(screen_cols));
                        row_i = clamp(int'(row) - int'($signed(db)),
                                      int'(screen_rows));
                        col = col_i[ps2mc_pkg::ColW-1:0];
                        row = row_i[ps2mc_pkg::RowW-1:0];
                        applied = 1'b1;
                    end
                end
            end
            r.buttons = buttons;
            r.col     = col;
            r.row     = row;
            r.applied = applied;
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [7:0] exp_v, logic [7:0] got_v);
            if (exp_v !== got_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_v, got_v);
            end
        endfunction

        function void check_result(cursor_state_t got);
            cursor_state_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: no result expected, got btn %0d col %0d row %0d applied %0d",
                         $time, got.buttons, got.col, got.row, got.applied);
                return;
            end
            exp_r = expected_q.pop_front();
            report("button_bits", 8'(exp_r.buttons), 8'(got.buttons));
            report("cursor_col", 8'(exp_r.col), 8'(got.col));
            report("cursor_row", 8'(exp_r.row), 8'(got.row));
            report("packet_applied", 8'(exp_r.applied), 8'(got.applied));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   req_gaps;
    bit   rsp_gaps;
    bit   hold_rsp;

    ps2mc_req_if req ();
    ps2mc_rsp_if rsp ();
    ps2mc_cfg_if cfg ();

    cursor_scoreboard board = new();

    ps2_mouse_packet_cursor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                board.write_reg(cfg.index, cfg.data);
            if (req.valid && req.ready)
                board.note_input(req.ctrl_status, req.rx_byte);
            if (rsp.valid && rsp.ready)
                board.check_result({rsp.button_bits, rsp.cursor_col,
                                    rsp.cursor_row, rsp.packet_applied});
        end
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (LongHold) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else if (rsp_gaps && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [ps2mc_pkg::ByteW-1:0] aux_status();
        return 8'($urandom) | ReadyAux;
    endfunction

    // status that makes the read ignored: not ready, or keyboard data
    function automatic logic [ps2mc_pkg::ByteW-1:0] ignored_status();
        logic [ps2mc_pkg::ByteW-1:0] s;
        s = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
            s[ps2mc_pkg::StReadyBit] = 1'b0;
        else
            s[ps2mc_pkg::StAuxBit] = 1'b0;
        return s;
    endfunction

    function automatic logic [ps2mc_pkg::ByteW-1:0] pick_delta();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 6) - 3);
    endfunction

    task automatic send_read(logic [ps2mc_pkg::ByteW-1:0] st,
                             logic [ps2mc_pkg::ByteW-1:0] db);
        if (req_gaps && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.ctrl_status <= st;
        req.rx_byte     <= db;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
    endtask

    task automatic send_packet(logic [ps2mc_pkg::ByteW-1:0] head,
                               logic [ps2mc_pkg::ByteW-1:0] dx,
                               logic [ps2mc_pkg::ByteW-1:0] dy);
        send_read(ReadyAux, head);
        send_read(ReadyAux, dx);
        send_read(ReadyAux, dy);
    endtask

    task automatic cfg_write(logic [ps2mc_pkg::CfgIdxW-1:0] idx,
                             logic [ps2mc_pkg::CfgDatW-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge clk);
        repeat (DrainWait) @(negedge clk);
    endtask

    task automatic set_screen(logic [ps2mc_pkg::CfgDatW-1:0] cols,
                              logic [ps2mc_pkg::CfgDatW-1:0] rows);
        settle();
        cfg_write(ps2mc_pkg::RegScreenColumns, cols);
        cfg_write(ps2mc_pkg::RegScreenRows, rows);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned                 sent;
        int unsigned                 kind;
        logic [ps2mc_pkg::ByteW-1:0] head;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
            begin
                head = 8'($urandom) | SyncMask;
                send_read(aux_status(), head);
                if (kind < 6)
                    send_read(ignored_status(), 8'($urandom));
                else if (kind < 9)
                    send_read(aux_status(), ps2mc_pkg::AckByte);
                send_read(aux_status(), pick_delta());
                send_read(aux_status(), pick_delta());
                sent += 3;
            end
            else if (kind < 86)
            begin
                send_read(ignored_status(), 8'($urandom));
                sent++;
            end
            else if (kind < 91)
            begin
                send_read(aux_status(), ps2mc_pkg::AckByte);
                sent++;
            end
            else
            begin
                send_read(8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        req.valid       = 1'b0;
        req.ctrl_status = '0;
        req.rx_byte     = '0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        req_gaps        = 1'b1;
        rsp_gaps        = 1'b1;
        hold_rsp        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ignored reads, extremes, bad sync, interleaved noise
        send_read(8'hDE, 8'h08);
        send_read(8'hDF, 8'h08);
        send_read(8'hFF, ps2mc_pkg::AckByte);
        send_packet(8'h0F, 8'h7F, 8'h80);
        send_packet(8'h08, 8'h80, 8'h7F);
        send_packet(8'hF7, 8'h05, 8'h05);
        send_read(ReadyAux, 8'h09);
        send_read(ReadyAux, ps2mc_pkg::AckByte);
        send_read(ReadyAux, 8'h01);
        send_read(8'h01, 8'h55);
        send_read(8'hFF, 8'hFF);
        send_packet(8'h0A, 8'h00, 8'h00);
        send_packet(8'hFC, 8'hAA, 8'h55);
        send_read(8'h00, 8'h00);
        send_read(8'hFF, 8'h00);

        set_screen(7'd127, 7'd31);
        hold_rsp = 1'b1;
        run_random(180);
        send_packet(8'h08, 8'h7F, 8'h80);
        send_packet(8'h08, 8'h7F, 8'h80);

        // shrink with the cursor far out; it stays until the next packet
        set_screen(7'd10, 7'h45);
        cfg_write(RegSpareA, 7'h7F);
        cfg_write(RegSpareB, 7'h00);
        req_gaps = 1'b0;
        send_read(ignored_status(), 8'h3C);
        run_random(170);

        set_screen(7'd1, 7'd1);
        req_gaps = 1'b1;
        rsp_gaps = 1'b0;
        run_random(150);

        set_screen(7'd0, 7'd0);
        rsp_gaps = 1'b1;
        run_random(150);

        set_screen(7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)));
        run_random(200);

        set_screen(7'd80, 7'd25);
        req_gaps = 1'b0;
        rsp_gaps = 1'b0;
        run_random(200);

        settle();
        repeat (8) @(negedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ps2mc_pkg.sv
rtl/ps2mc_if.sv
rtl/ps2_mouse_packet_cursor.sv
dv/ps2_mouse_packet_cursor_test.sv
